// ===== src/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Shared types, operation codes and a word-wrapping helper for the Q24.8 ALU pipeline.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int WORD_WIDTH = 32;
    localparam int DATA_W     = 32;
    localparam int NUM_MAX_W  = 48;

    typedef enum logic [3:0] {
        FN_ADD      = 4'd0,
        FN_SUB      = 4'd1,
        FN_MUL      = 4'd2,
        FN_DIV      = 4'd3,
        FN_GT       = 4'd4,
        FN_LT       = 4'd5,
        FN_GE       = 4'd6,
        FN_LE       = 4'd7,
        FN_EQ       = 4'd8,
        FN_NE       = 4'd9,
        FN_INC      = 4'd10,
        FN_DEC      = 4'd11,
        FN_MIN      = 4'd12,
        FN_MAX      = 4'd13,
        FN_FROM_INT = 4'd14,
        FN_TO_INT   = 4'd15
    } t_func;

    typedef struct packed {
        t_func                  func;
        logic [DATA_W-1:0]      res;
        logic                   cond;
        logic                   dz;
        logic                   neg;
        logic [DATA_W:0]        rem;
        logic [NUM_MAX_W-1:0]   num;
        logic [DATA_W-1:0]      den;
        logic [2*DATA_W-1:0]    prod;
    } t_pipe;

    function automatic logic [DATA_W-1:0] wrap_word(input logic [63:0] x, input int w);
        logic [63:0] t;
        begin
            t = x;
            if (w < DATA_W) begin
                t = x << (64 - w);
                t = 64'($signed(t) >>> (64 - w));
            end
            return t[DATA_W-1:0];
        end
    endfunction

endpackage

// ===== src/fpa_front.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU front stage
// Decodes the operation, forms simple results, the product and divide setup.
// ----------------------------------------------------------------------------
module fpa_front #(
    parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS,
    parameter int WORD_WIDTH = fpa_pkg::WORD_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [3:0]                  i_func,
    input  logic [fpa_pkg::DATA_W-1:0]  i_operand_a,
    input  logic [fpa_pkg::DATA_W-1:0]  i_operand_b,
    output logic                        o_valid,
    input  logic                        i_ready,
    output fpa_pkg::t_pipe              o_data
);

    logic                   r_valid;
    fpa_pkg::t_pipe         r_data;
    fpa_pkg::t_pipe         n_data;
    logic signed [31:0]     a;
    logic signed [31:0]     b;
    logic signed [63:0]     a64;
    logic signed [63:0]     b64;
    logic [32:0]            mag_a;
    logic [31:0]            mag_b;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        a     = fpa_pkg::wrap_word({{32{i_operand_a[31]}}, i_operand_a}, WORD_WIDTH);
        b     = fpa_pkg::wrap_word({{32{i_operand_b[31]}}, i_operand_b}, WORD_WIDTH);
        a64   = 64'(a);
        b64   = 64'(b);
        mag_a = a[31] ? 33'(-a64) : 33'(a64);
        mag_b = b[31] ? 32'(-b64) : 32'(b64);
        n_data      = '0;
        n_data.func = fpa_pkg::t_func'(i_func);
        n_data.prod = a64 * b64;
        n_data.neg  = a[31] ^ b[31];
        n_data.den  = mag_b;
        n_data.num  = fpa_pkg::NUM_MAX_W'(mag_a) << FRAC_BITS;
        case (fpa_pkg::t_func'(i_func))
            fpa_pkg::FN_ADD:      n_data.res  = fpa_pkg::wrap_word(a64 + b64, WORD_WIDTH);
            fpa_pkg::FN_SUB:      n_data.res  = fpa_pkg::wrap_word(a64 - b64, WORD_WIDTH);
            fpa_pkg::FN_DIV:      n_data.dz   = (b == 32'sd0);
            fpa_pkg::FN_GT:       n_data.cond = a > b;
            fpa_pkg::FN_LT:       n_data.cond = a < b;
            fpa_pkg::FN_GE:       n_data.cond = a >= b;
            fpa_pkg::FN_LE:       n_data.cond = a <= b;
            fpa_pkg::FN_EQ:       n_data.cond = a == b;
            fpa_pkg::FN_NE:       n_data.cond = a != b;
            fpa_pkg::FN_INC:      n_data.res  = fpa_pkg::wrap_word(a64 + 64'sd1, WORD_WIDTH);
            fpa_pkg::FN_DEC:      n_data.res  = fpa_pkg::wrap_word(a64 - 64'sd1, WORD_WIDTH);
            fpa_pkg::FN_MIN:      n_data.res  = fpa_pkg::wrap_word((a > b) ? b64 : a64, WORD_WIDTH);
            fpa_pkg::FN_MAX:      n_data.res  = fpa_pkg::wrap_word((a > b) ? a64 : b64, WORD_WIDTH);
            fpa_pkg::FN_FROM_INT: n_data.res  = fpa_pkg::wrap_word(a64 <<< FRAC_BITS, WORD_WIDTH);
            fpa_pkg::FN_TO_INT:   n_data.res  = fpa_pkg::wrap_word(a64 >>> FRAC_BITS, WORD_WIDTH);
            default:              n_data.res  = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== src/fpa_mul_stage.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU product stage
// Scales the registered product and clears the divider remainder.
// ----------------------------------------------------------------------------
module fpa_mul_stage #(
    parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS,
    parameter int WORD_WIDTH = fpa_pkg::WORD_WIDTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  fpa_pkg::t_pipe  i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output fpa_pkg::t_pipe  o_data
);

    logic           r_valid;
    fpa_pkg::t_pipe r_data;
    fpa_pkg::t_pipe n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data     = i_data;
        n_data.rem = '0;
        if (i_data.func == fpa_pkg::FN_MUL) begin
            n_data.res = fpa_pkg::wrap_word(64'($signed(i_data.prod) >>> FRAC_BITS),
                                            WORD_WIDTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== src/fpa_div_step.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU divider step
// One restoring division step: brings in one dividend bit, yields one quotient bit.
// ----------------------------------------------------------------------------
module fpa_div_step #(
    parameter int NUM_W = fpa_pkg::DATA_W + fpa_pkg::FRAC_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  fpa_pkg::t_pipe  i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output fpa_pkg::t_pipe  o_data
);

    logic                       r_valid;
    fpa_pkg::t_pipe             r_data;
    fpa_pkg::t_pipe             n_data;
    logic [fpa_pkg::DATA_W:0]   trial;
    logic                       q_bit;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data = i_data;
        trial  = {i_data.rem[fpa_pkg::DATA_W-1:0], i_data.num[NUM_W-1]};
        q_bit  = trial >= {1'b0, i_data.den};
        n_data.rem = q_bit ? (trial - {1'b0, i_data.den}) : trial;
        n_data.num = {i_data.num[fpa_pkg::NUM_MAX_W-2:0], q_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== src/fpa_back.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU output stage
// Signs and wraps the quotient and holds the finished result for the consumer.
// ----------------------------------------------------------------------------
module fpa_back #(
    parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS,
    parameter int WORD_WIDTH = fpa_pkg::WORD_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  fpa_pkg::t_pipe              i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [fpa_pkg::DATA_W-1:0]  o_result,
    output logic                        o_condition,
    output logic                        o_divide_by_zero
);

    localparam int NUM_W = fpa_pkg::DATA_W + FRAC_BITS;

    logic                       r_valid;
    logic [fpa_pkg::DATA_W-1:0] r_result;
    logic                       r_condition;
    logic                       r_divide_by_zero;
    logic [fpa_pkg::DATA_W-1:0] n_result;
    logic [63:0]                quot;

    assign o_ready          = !r_valid || i_ready;
    assign o_valid          = r_valid;
    assign o_result         = r_result;
    assign o_condition      = r_condition;
    assign o_divide_by_zero = r_divide_by_zero;

    always_comb begin
        quot     = 64'(i_data.num[NUM_W-1:0]);
        n_result = i_data.res;
        if (i_data.func == fpa_pkg::FN_DIV) begin
            if (i_data.dz) begin
                n_result = '0;
            end else begin
                n_result = fpa_pkg::wrap_word(i_data.neg ? (64'd0 - quot) : quot, WORD_WIDTH);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_result         <= n_result;
            r_condition      <= i_data.cond;
            r_divide_by_zero <= i_data.dz;
        end
    end

endmodule

// ===== src/fixed_point_alu_q24_8.sv =====
// ----------------------------------------------------------------------------
// Q24.8 fixed-point ALU
// Pipelined signed fixed-point arithmetic, comparison and conversion unit.
// ----------------------------------------------------------------------------
// Every operation takes the same path, so results leave in the order the
// transactions were accepted. The unit accepts one transaction per cycle unless
// the pipeline is full and stalled. The path is one decode stage, one product
// scaling stage, one restoring divider step per quotient bit (32 + FRAC_BITS
// steps), and one output register. Each stage holds its contents while the
// stage after it is full and stalled.
module fixed_point_alu_q24_8 #(
    parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS,
    parameter int WORD_WIDTH = fpa_pkg::WORD_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [3:0]                  i_func,
    input  logic [fpa_pkg::DATA_W-1:0]  i_operand_a,
    input  logic [fpa_pkg::DATA_W-1:0]  i_operand_b,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [fpa_pkg::DATA_W-1:0]  o_result,
    output logic                        o_condition,
    output logic                        o_divide_by_zero
);

    localparam int NUM_W = fpa_pkg::DATA_W + FRAC_BITS;

    logic           st_valid [NUM_W+2];
    logic           st_ready [NUM_W+2];
    fpa_pkg::t_pipe st_data  [NUM_W+2];

    fpa_front #(
        .FRAC_BITS  (FRAC_BITS),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_valid     (st_valid[0]),
        .i_ready     (st_ready[0]),
        .o_data      (st_data[0])
    );

    fpa_mul_stage #(
        .FRAC_BITS  (FRAC_BITS),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (st_valid[0]),
        .o_ready (st_ready[0]),
        .i_data  (st_data[0]),
        .o_valid (st_valid[1]),
        .i_ready (st_ready[1]),
        .o_data  (st_data[1])
    );

    for (genvar g = 0; g < NUM_W; g++) begin : g_div
        fpa_div_step #(
            .NUM_W (NUM_W)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[g+1]),
            .o_ready (st_ready[g+1]),
            .i_data  (st_data[g+1]),
            .o_valid (st_valid[g+2]),
            .i_ready (st_ready[g+2]),
            .o_data  (st_data[g+2])
        );
    end

    fpa_back #(
        .FRAC_BITS  (FRAC_BITS),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (st_valid[NUM_W+1]),
        .o_ready          (st_ready[NUM_W+1]),
        .i_data           (st_data[NUM_W+1]),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result         (o_result),
        .o_condition      (o_condition),
        .o_divide_by_zero (o_divide_by_zero)
    );

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Q24.8 fixed-point ALU testbench
// Drives directed and random operations through the valid/ready input channel,
// predicts each outcome with a behavioral fixed-point model and compares every
// output transaction in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        fpa_pkg::t_func func;
        logic [31:0]    a;
        logic [31:0]    b;
    } op_t;

    typedef struct {
        logic [31:0] res;
        logic        cond;
        logic        dz;
    } alu_out_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [3:0]  i_func = 4'd0;
    logic [31:0] i_operand_a = '0;
    logic [31:0] i_operand_b = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_result;
    logic        o_condition;
    logic        o_divide_by_zero;

    op_t      pending_ops[$];
    alu_out_t expected_outs[$];
    int       mismatches = 0;
    int       cycles = 0;
    int       accepted_ops = 0;
    bit       calm = 1'b0;
    bit       hold_off = 1'b0;
    bit       stim_done = 1'b0;

    fixed_point_alu_q24_8 dut (.*);

    always #2 i_clk = ~i_clk;

    function automatic alu_out_t compute_alu(op_t op);
        alu_out_t o;
        longint a, b, p, num, q;
        a = longint'($signed(op.a));
        b = longint'($signed(op.b));
        o.res = '0;
        o.cond = 1'b0;
        o.dz = 1'b0;
        case (op.func)
            fpa_pkg::FN_ADD: o.res = 32'(a + b);
            fpa_pkg::FN_SUB: o.res = 32'(a - b);
            fpa_pkg::FN_MUL: begin
                p = a * b;
                o.res = 32'(p >>> fpa_pkg::FRAC_BITS);
            end
            fpa_pkg::FN_DIV: begin
                if (b == 0) begin
                    o.dz = 1'b1;
                end else begin
                    num = a * (longint'(1) << fpa_pkg::FRAC_BITS);
                    q = num / b;
                    o.res = 32'(q);
                end
            end
            fpa_pkg::FN_GT: o.cond = a > b;
            fpa_pkg::FN_LT: o.cond = a < b;
            fpa_pkg::FN_GE: o.cond = a >= b;
            fpa_pkg::FN_LE: o.cond = a <= b;
            fpa_pkg::FN_EQ: o.cond = a == b;
            fpa_pkg::FN_NE: o.cond = a != b;
            fpa_pkg::FN_INC: o.res = 32'(a + 1);
            fpa_pkg::FN_DEC: o.res = 32'(a - 1);
            fpa_pkg::FN_MIN: o.res = (a > b) ? op.b : op.a;
            fpa_pkg::FN_MAX: o.res = (a > b) ? op.a : op.b;
            fpa_pkg::FN_FROM_INT: o.res = 32'(a * (longint'(1) << fpa_pkg::FRAC_BITS));
            default: o.res = 32'(a >>> fpa_pkg::FRAC_BITS);
        endcase
        return o;
    endfunction

    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0: v = 32'h8000_0000;
            1: v = 32'h7fff_ffff;
            2: v = '0;
            3: v = 32'($signed($urandom_range(0, 4096)) - 2048);
            4: v = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic add_op(fpa_pkg::t_func f, logic [31:0] a, logic [31:0] b);
        op_t op;
        op.func = f;
        op.a = a;
        op.b = b;
        pending_ops.push_back(op);
    endtask

    // Driver: valid stays up with a stable payload until the transaction is taken.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_outs.push_back(compute_alu(pending_ops.pop_front()));
                accepted_ops <= accepted_ops + 1;
            end
            if (!(i_valid && !o_ready)) begin
                if (pending_ops.size() > 0 && !hold_off &&
                    (calm || $urandom_range(0, 99) >= 26)) begin
                    i_valid <= 1'b1;
                    i_func <= pending_ops[0].func;
                    i_operand_a <= pending_ops[0].a;
                    i_operand_b <= pending_ops[0].b;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each output transaction against the oldest prediction.
    always @(posedge i_clk) begin
        alu_out_t exp_out;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_outs.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("Unexpected output: result=%h cond=%b dz=%b",
                                 o_result, o_condition, o_divide_by_zero);
                end else begin
                    exp_out = expected_outs.pop_front();
                    if (o_result !== exp_out.res || o_condition !== exp_out.cond ||
                        o_divide_by_zero !== exp_out.dz) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("Mismatch: exp %h/%b/%b got %h/%b/%b",
                                     exp_out.res, exp_out.cond, exp_out.dz,
                                     o_result, o_condition, o_divide_by_zero);
                    end
                end
            end
            i_ready <= calm || ($urandom_range(0, 99) >= 26);
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 200000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [31:0] edges[5];
        int n_dir;
        edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h0000_0100};
        for (int f = 0; f < 16; f++)
            add_op(fpa_pkg::t_func'(f), edges[f % 5], edges[(f + 2) % 5]);
        add_op(fpa_pkg::FN_DIV, 32'h0000_0500, 32'h0);
        add_op(fpa_pkg::FN_DIV, 32'h8000_0000, 32'hffff_ffff);
        add_op(fpa_pkg::FN_DIV, 32'hffff_fd00, 32'h0000_0200);
        add_op(fpa_pkg::FN_MUL, 32'h8000_0000, 32'h8000_0000);
        add_op(fpa_pkg::FN_MIN, 32'h0000_0123, 32'h0000_0123);
        add_op(fpa_pkg::FN_MAX, 32'h0000_0123, 32'h0000_0123);
        add_op(fpa_pkg::FN_TO_INT, 32'hffff_ff01, 32'h0);
        n_dir = pending_ops.size();
        for (int i = 0; i < 400; i++)
            add_op(fpa_pkg::t_func'($urandom_range(0, 15)), pick_operand(),
                   ($urandom_range(0, 15) == 0) ? 32'h0 : pick_operand());
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (accepted_ops >= n_dir);
        @(posedge i_clk);
        hold_off <= 1'b1;
        wait (expected_outs.size() == 0);
        @(posedge i_clk);
        hold_off <= 1'b0;
        wait (accepted_ops >= n_dir + 150);
        calm <= 1'b1;
        wait (accepted_ops >= n_dir + 250);
        calm <= 1'b0;
        wait (pending_ops.size() == 0);
        wait (expected_outs.size() == 0);
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && expected_outs.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
